@@ rtl/ntt7_pkg.sv @@
// Shared types, constants and modular arithmetic helpers for the radix-7 NTT butterfly.
package ntt7_pkg;

    localparam int WORD_BITS = 62;
    localparam int NUM_RES   = 7;
    localparam int NUM_K     = 8;
    localparam int NUM_LANES = NUM_RES + NUM_K;
    localparam int PRE_STAGES = 3;
    localparam int POST_STAGES = 4;
    // Register stages from an accepted transform request to its result on the output register.
    localparam int LATENCY = WORD_BITS + PRE_STAGES + WORD_BITS + POST_STAGES;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [2:0] kidx_t;

    typedef enum logic
    {
        OP_LOAD  = 1'b0,
        OP_XFORM = 1'b1
    } opcode_t;

    localparam word_t MIN_MODULUS = word_t'(3);

    // Modular add of two reduced operands.
    function automatic word_t mod_add(input word_t a, input word_t b, input word_t m);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            return word_t'(s - {1'b0, m});
        end
        return s[WORD_BITS-1:0];
    endfunction

    // Modular subtract of two reduced operands.
    function automatic word_t mod_sub(input word_t a, input word_t b, input word_t m);
        logic [WORD_BITS:0] d;
        if (a >= b)
        begin
            d = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            d = {1'b0, a} + {1'b0, m} - {1'b0, b};
        end
        return d[WORD_BITS-1:0];
    endfunction

endpackage

@@ rtl/ntt7_if.sv @@
// Request and result channel interfaces of the radix-7 NTT butterfly.
interface ntt7_in_if import ntt7_pkg::*; ();
    logic    valid;
    logic    ready;
    opcode_t opcode;
    kidx_t   const_index;
    word_t   const_value;
    word_t   in_0;
    word_t   in_1;
    word_t   in_2;
    word_t   in_3;
    word_t   in_4;
    word_t   in_5;
    word_t   in_6;

    modport source (output valid, opcode, const_index, const_value,
                    in_0, in_1, in_2, in_3, in_4, in_5, in_6, input ready);
    modport sink (input valid, opcode, const_index, const_value,
                  in_0, in_1, in_2, in_3, in_4, in_5, in_6, output ready);
endinterface

interface ntt7_out_if import ntt7_pkg::*; ();
    logic  valid;
    logic  ready;
    word_t out_0;
    word_t out_1;
    word_t out_2;
    word_t out_3;
    word_t out_4;
    word_t out_5;
    word_t out_6;

    modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
                    input ready);
    modport sink (input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6,
                  output ready);
endinterface

@@ rtl/ntt7_reduce.sv @@
// Pipelined restoring reduction of one word modulo the modulus, one bit per stage.
module ntt7_reduce import ntt7_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t m,
    input  word_t x,
    output word_t r
);

    word_t rem_reg [WORD_BITS];
    word_t xs_reg  [WORD_BITS-1];

    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_stage
        word_t              r_in;
        word_t              x_in;
        logic [WORD_BITS:0] trial;

        if (i == 0)
        begin : g_first
            assign r_in = '0;
            assign x_in = x;
        end
        else
        begin : g_rest
            assign r_in = rem_reg[i-1];
            assign x_in = xs_reg[i-1];
        end

        // Shift in the next dividend bit and subtract the modulus when it fits.
        assign trial = {r_in, x_in[WORD_BITS-1]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (trial >= {1'b0, m})
                begin
                    rem_reg[i] <= word_t'(trial - {1'b0, m});
                end
                else
                begin
                    rem_reg[i] <= trial[WORD_BITS-1:0];
                end
            end
        end

        if (i < WORD_BITS - 1)
        begin : g_shift
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    xs_reg[i] <= {x_in[WORD_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign r = rem_reg[WORD_BITS-1];

endmodule

@@ rtl/ntt7_mul.sv @@
// Pipelined modular multiplier lane: one multiplier bit per stage, most significant first.
module ntt7_mul import ntt7_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t m,
    input  word_t a,
    input  word_t b,
    output word_t p
);

    word_t acc_reg [WORD_BITS];
    word_t a_reg   [WORD_BITS-1];
    word_t b_reg   [WORD_BITS-1];

    logic [WORD_BITS+1:0] m1;
    logic [WORD_BITS+1:0] m2;

    assign m1 = {2'b00, m};
    assign m2 = {1'b0, m, 1'b0};

    for (genvar i = 0; i < WORD_BITS; i++)
    begin : g_stage
        word_t                r_in;
        word_t                a_in;
        word_t                b_in;
        logic [WORD_BITS+1:0] sum;

        if (i == 0)
        begin : g_first
            assign r_in = '0;
            assign a_in = a;
            assign b_in = b;
        end
        else
        begin : g_rest
            assign r_in = acc_reg[i-1];
            assign a_in = a_reg[i-1];
            assign b_in = b_reg[i-1];
        end

        // Double and add; the sum stays below three times the modulus.
        assign sum = {1'b0, r_in, 1'b0} + {2'b00, (b_in[WORD_BITS-1] ? a_in : '0)};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (sum >= m2)
                begin
                    acc_reg[i] <= word_t'(sum - m2);
                end
                else if (sum >= m1)
                begin
                    acc_reg[i] <= word_t'(sum - m1);
                end
                else
                begin
                    acc_reg[i] <= sum[WORD_BITS-1:0];
                end
            end
        end

        if (i < WORD_BITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[i] <= a_in;
                    b_reg[i] <= {b_in[WORD_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign p = acc_reg[WORD_BITS-1];

endmodule

@@ rtl/ntt7_presum.sv @@
// Input sum and difference network ahead of the constant multiplies, three stages.
module ntt7_presum import ntt7_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t m,
    input  word_t x_in  [NUM_RES],
    input  word_t k_in  [NUM_K],
    output word_t op_out [NUM_K],
    output word_t k_out [NUM_K],
    output word_t q0_out
);

    word_t a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a6_reg, x0_a_reg;
    word_t t12_reg, x0a3_reg, d45_reg, a3_b_reg, a6_b_reg;
    word_t s2_b_reg, s3_b_reg, s5_b_reg, s6_b_reg;
    word_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s23_reg, s56_reg, q0_reg;
    word_t k_a_reg [NUM_K];
    word_t k_b_reg [NUM_K];
    word_t k_c_reg [NUM_K];

    // First stage: pairwise sums and differences.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a1_reg   <= mod_add(x_in[1], x_in[4], m);
            a2_reg   <= mod_add(x_in[2], x_in[5], m);
            a3_reg   <= mod_add(x_in[3], x_in[6], m);
            a4_reg   <= mod_sub(x_in[1], x_in[4], m);
            a5_reg   <= mod_sub(x_in[2], x_in[5], m);
            a6_reg   <= mod_sub(x_in[3], x_in[6], m);
            x0_a_reg <= x_in[0];
            k_a_reg  <= k_in;
        end
    end

    // Second stage: partial sums and the simple differences.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t12_reg  <= mod_add(a1_reg, a2_reg, m);
            x0a3_reg <= mod_add(x0_a_reg, a3_reg, m);
            d45_reg  <= mod_sub(a4_reg, a5_reg, m);
            s2_b_reg <= mod_sub(a1_reg, a3_reg, m);
            s3_b_reg <= mod_sub(a2_reg, a3_reg, m);
            s5_b_reg <= mod_sub(a4_reg, a6_reg, m);
            s6_b_reg <= mod_add(a5_reg, a6_reg, m);
            a3_b_reg <= a3_reg;
            a6_b_reg <= a6_reg;
            k_b_reg  <= k_a_reg;
        end
    end

    // Third stage: multiplier operands and the direct term.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_reg  <= mod_add(t12_reg, a3_b_reg, m);
            s4_reg  <= mod_add(d45_reg, a6_b_reg, m);
            s2_reg  <= s2_b_reg;
            s3_reg  <= s3_b_reg;
            s5_reg  <= s5_b_reg;
            s6_reg  <= s6_b_reg;
            s23_reg <= mod_add(s2_b_reg, s3_b_reg, m);
            s56_reg <= mod_add(s5_b_reg, s6_b_reg, m);
            q0_reg  <= mod_add(t12_reg, x0a3_reg, m);
            k_c_reg <= k_b_reg;
        end
    end

    assign op_out[0] = s1_reg;
    assign op_out[1] = s2_reg;
    assign op_out[2] = s3_reg;
    assign op_out[3] = s23_reg;
    assign op_out[4] = s4_reg;
    assign op_out[5] = s5_reg;
    assign op_out[6] = s6_reg;
    assign op_out[7] = s56_reg;
    assign k_out     = k_c_reg;
    assign q0_out    = q0_reg;

endmodule

@@ rtl/ntt7_combine.sv @@
// Merging network that recombines the lane products into the seven outputs, four stages.
module ntt7_combine import ntt7_pkg::*;
(
    input  logic  clk,
    input  logic  en,
    input  word_t m,
    input  word_t q0,
    input  word_t q_in [NUM_K],
    output word_t y [NUM_RES]
);

    word_t c0_1_reg, s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg;
    word_t c0_2_reg, a1_2_reg, a2_2_reg, t_reg, a4_2_reg, a5_2_reg, u_reg, s3_2_reg, s6_2_reg;
    word_t c0_3_reg, a1_reg, a2_reg, a3_reg, a4_reg, a5_reg, a6_reg;
    word_t y_reg [NUM_RES];

    // First stage: fold the shared products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_1_reg <= q0;
            s1_reg   <= mod_add(q0, q_in[0], m);
            s2_reg   <= mod_add(q_in[1], q_in[3], m);
            s3_reg   <= mod_add(q_in[2], q_in[3], m);
            s4_reg   <= q_in[4];
            s5_reg   <= mod_add(q_in[5], q_in[7], m);
            s6_reg   <= mod_add(q_in[6], q_in[7], m);
        end
    end

    // Second stage: first level of recombination.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_2_reg <= c0_1_reg;
            a1_2_reg <= mod_add(s1_reg, s2_reg, m);
            a2_2_reg <= mod_add(s1_reg, s3_reg, m);
            t_reg    <= mod_sub(s1_reg, s2_reg, m);
            a4_2_reg <= mod_add(s4_reg, s5_reg, m);
            a5_2_reg <= mod_sub(s6_reg, s4_reg, m);
            u_reg    <= mod_sub(s4_reg, s5_reg, m);
            s3_2_reg <= s3_reg;
            s6_2_reg <= s6_reg;
        end
    end

    // Third stage: finish the three-term combinations.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c0_3_reg <= c0_2_reg;
            a1_reg   <= a1_2_reg;
            a2_reg   <= a2_2_reg;
            a3_reg   <= mod_sub(t_reg, s3_2_reg, m);
            a4_reg   <= a4_2_reg;
            a5_reg   <= a5_2_reg;
            a6_reg   <= mod_add(u_reg, s6_2_reg, m);
        end
    end

    // Fourth stage: output butterflies in the permuted output order.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg[0] <= c0_3_reg;
            y_reg[1] <= mod_sub(a3_reg, a6_reg, m);
            y_reg[2] <= mod_sub(a1_reg, a4_reg, m);
            y_reg[3] <= mod_sub(a2_reg, a5_reg, m);
            y_reg[4] <= mod_add(a2_reg, a5_reg, m);
            y_reg[5] <= mod_add(a1_reg, a4_reg, m);
            y_reg[6] <= mod_add(a3_reg, a6_reg, m);
        end
    end

    assign y = y_reg;

endmodule

@@ rtl/ntt_radix7_butterfly_unit.sv @@
// Top level of the radix-7 NTT butterfly: constant table, reduction and multiplier lanes.
//
// Requests arrive on req. A load request (opcode OP_LOAD) writes const_value into
// table entry const_index at the accepting edge and produces no result. A transform
// request (opcode OP_XFORM) carries seven residues and produces one result on res.
// The user must write the modulus through cfg_wr_en and cfg_wr_data only while the block
// is idle; the block does not enforce this. Values below three are stored as three.
// Throughput is one request per cycle while res is not stalled. A transform result
// reaches res through 62 one-bit reduction stages, three sum stages, 62 one-bit
// multiplier stages and four recombination stages.
// Fifteen reduction lanes and eight multiplier lanes run side by side.
// Table constants are read when a transform request is accepted.
// When res is stalled the whole pipeline holds and req.ready drops; it rises again
// in the cycle the waiting result is taken.
// Reset clears the modulus to three and empties the pipeline; the constant table
// holds no defined value until each entry is loaded.
module ntt_radix7_butterfly_unit import ntt7_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  word_t      cfg_wr_data,
    ntt7_in_if.sink    req,
    ntt7_out_if.source res
);

    word_t modulus_reg;
    word_t table_reg [NUM_K];
    logic [LATENCY-1:0] vld_reg;
    word_t q0_dly_reg [WORD_BITS];

    logic  en;
    logic  take;
    word_t red_in   [NUM_LANES];
    word_t red_out  [NUM_LANES];
    word_t x_perm   [NUM_RES];
    word_t k_red    [NUM_K];
    word_t mul_op   [NUM_K];
    word_t mul_k    [NUM_K];
    word_t q0_pre;
    word_t prod     [NUM_K];
    word_t y        [NUM_RES];

    // Pipeline advances unless a result is waiting and not taken.
    assign en        = !vld_reg[LATENCY-1] || res.ready;
    assign req.ready = en;
    assign take      = req.valid && en;

    // Modulus register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MIN_MODULUS;
        end
        else if (cfg_wr_en)
        begin
            modulus_reg <= (cfg_wr_data < MIN_MODULUS) ? MIN_MODULUS : cfg_wr_data;
        end
    end

    // Constant table, written by load requests.
    always_ff @(posedge clk)
    begin
        if (take && req.opcode == OP_LOAD)
        begin
            table_reg[req.const_index] <= req.const_value;
        end
    end

    // Valid tracking along the pipeline.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LATENCY-2:0], take && req.opcode == OP_XFORM};
        end
    end

    // Reduction lanes: seven residues followed by the eight constants.
    assign red_in[0] = req.in_0;
    assign red_in[1] = req.in_1;
    assign red_in[2] = req.in_2;
    assign red_in[3] = req.in_3;
    assign red_in[4] = req.in_4;
    assign red_in[5] = req.in_5;
    assign red_in[6] = req.in_6;
    for (genvar j = 0; j < NUM_K; j++)
    begin : g_kin
        assign red_in[NUM_RES+j] = table_reg[j];
        assign k_red[j]          = red_out[NUM_RES+j];
    end

    for (genvar l = 0; l < NUM_LANES; l++)
    begin : g_red
        ntt7_reduce u_reduce
        (
            .clk (clk),
            .en  (en),
            .m   (modulus_reg),
            .x   (red_in[l]),
            .r   (red_out[l])
        );
    end

    // Input permutation of the butterfly.
    assign x_perm[0] = red_out[0];
    assign x_perm[1] = red_out[1];
    assign x_perm[5] = red_out[2];
    assign x_perm[6] = red_out[3];
    assign x_perm[3] = red_out[4];
    assign x_perm[2] = red_out[5];
    assign x_perm[4] = red_out[6];

    ntt7_presum u_presum
    (
        .clk    (clk),
        .en     (en),
        .m      (modulus_reg),
        .x_in   (x_perm),
        .k_in   (k_red),
        .op_out (mul_op),
        .k_out  (mul_k),
        .q0_out (q0_pre)
    );

    // Constant multiplier lanes.
    for (genvar l = 0; l < NUM_K; l++)
    begin : g_mul
        ntt7_mul u_mul
        (
            .clk (clk),
            .en  (en),
            .m   (modulus_reg),
            .a   (mul_op[l]),
            .b   (mul_k[l]),
            .p   (prod[l])
        );
    end

    // Direct term delayed to line up with the products.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q0_dly_reg[0] <= q0_pre;
            for (int i = 1; i < WORD_BITS; i++)
            begin
                q0_dly_reg[i] <= q0_dly_reg[i-1];
            end
        end
    end

    ntt7_combine u_combine
    (
        .clk  (clk),
        .en   (en),
        .m    (modulus_reg),
        .q0   (q0_dly_reg[WORD_BITS-1]),
        .q_in (prod),
        .y    (y)
    );

    assign res.valid = vld_reg[LATENCY-1];
    assign res.out_0 = y[0];
    assign res.out_1 = y[1];
    assign res.out_2 = y[2];
    assign res.out_3 = y[3];
    assign res.out_4 = y[4];
    assign res.out_5 = y[5];
    assign res.out_6 = y[6];

    // A stalled result blocks new requests.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |-> !req.ready)
        else $error("request accepted while a result is stalled");

    // A load request never starts a result.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.opcode == OP_LOAD |=> !vld_reg[0])
        else $error("load request entered the pipeline");

    // The pipeline holds while the output stalls.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

    // The modulus never drops below three.
    a_modulus_min: assert property (@(posedge clk) disable iff (!rst_n)
        modulus_reg >= MIN_MODULUS)
        else $error("modulus below three");

endmodule

@@ tb/sv/tb_ntt_radix7_butterfly_unit.sv @@
// Self-checking testbench for the radix-7 NTT butterfly unit with its own transform predictor.
module tb_ntt_radix7_butterfly_unit;
    import ntt7_pkg::*;

    typedef struct {
        opcode_t op;
        kidx_t   idx;
        word_t   cval;
        word_t   x [NUM_RES];
    } request_t;

    typedef struct {
        word_t v [NUM_RES];
    } residues_t;

    localparam word_t WORD_ONES = {WORD_BITS{1'b1}};

    logic  clk;
    logic  rst_n;
    logic  cfg_wr_en;
    word_t cfg_wr_data;

    ntt7_in_if  req ();
    ntt7_out_if res ();

    ntt_radix7_butterfly_unit DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req.sink),
        .res         (res.source)
    );

    // Predictor state: modulus and the transform constant table.
    word_t     cur_modulus;
    word_t     const_table [NUM_K];
    residues_t pending_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int recv_hold_left;
    int mismatch_count;
    int xform_count;
    int load_count;
    int result_count;
    int modulus_count;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Safety limit on the whole run.
    initial
    begin
        #3000000;
        $display("Some tests failed");
        $finish;
    end

    // Modular arithmetic of the predictor on reduced operands.
    function automatic word_t res_add(word_t a, word_t b, word_t m);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
        begin
            s = s - {1'b0, m};
        end
        return s[WORD_BITS-1:0];
    endfunction

    function automatic word_t res_sub(word_t a, word_t b, word_t m);
        logic [WORD_BITS:0] d;
        if (a >= b)
        begin
            d = {1'b0, a} - {1'b0, b};
        end
        else
        begin
            d = {1'b0, a} + {1'b0, m} - {1'b0, b};
        end
        return d[WORD_BITS-1:0];
    endfunction

    function automatic word_t res_mul(word_t a, word_t b, word_t m);
        word_t acc;
        acc = '0;
        for (int bitpos = WORD_BITS - 1; bitpos >= 0; bitpos--)
        begin
            acc = res_add(acc, acc, m);
            if (b[bitpos])
            begin
                acc = res_add(acc, a, m);
            end
        end
        return acc;
    endfunction

    // Full butterfly: permuted inputs, sums, eight constant products, recombination.
    function automatic residues_t butterfly7(request_t r);
        word_t m;
        word_t k [NUM_K];
        word_t x0, x1, x2, x3, x4, x5, x6;
        word_t a1, a2, a3, a4, a5, a6;
        word_t s1, s2, s3, s4, s5, s6;
        word_t q0, q1, q2, q3, q4, q5, q6, q7, q8;
        residues_t o;
        m = cur_modulus;
        for (int i = 0; i < NUM_K; i++)
        begin
            k[i] = const_table[i] % m;
        end
        x0 = r.x[0] % m;
        x1 = r.x[1] % m;
        x5 = r.x[2] % m;
        x6 = r.x[3] % m;
        x3 = r.x[4] % m;
        x2 = r.x[5] % m;
        x4 = r.x[6] % m;

        a1 = res_add(x1, x4, m);
        a2 = res_add(x2, x5, m);
        a3 = res_add(x3, x6, m);
        a4 = res_sub(x1, x4, m);
        a5 = res_sub(x2, x5, m);
        a6 = res_sub(x3, x6, m);

        s1 = res_add(res_add(a1, a2, m), a3, m);
        s2 = res_sub(a1, a3, m);
        s3 = res_sub(a2, a3, m);
        s4 = res_add(res_sub(a4, a5, m), a6, m);
        s5 = res_sub(a4, a6, m);
        s6 = res_add(a5, a6, m);

        q0 = res_add(x0, s1, m);
        q1 = res_mul(s1, k[0], m);
        q2 = res_mul(s2, k[1], m);
        q3 = res_mul(s3, k[2], m);
        q4 = res_mul(res_add(s2, s3, m), k[3], m);
        q5 = res_mul(s4, k[4], m);
        q6 = res_mul(s5, k[5], m);
        q7 = res_mul(s6, k[6], m);
        q8 = res_mul(res_add(s5, s6, m), k[7], m);

        s1 = res_add(q0, q1, m);
        s2 = res_add(q2, q4, m);
        s3 = res_add(q3, q4, m);
        s4 = q5;
        s5 = res_add(q6, q8, m);
        s6 = res_add(q7, q8, m);

        a1 = res_add(s1, s2, m);
        a2 = res_add(s1, s3, m);
        a3 = res_sub(res_sub(s1, s2, m), s3, m);
        a4 = res_add(s4, s5, m);
        a5 = res_sub(s6, s4, m);
        a6 = res_add(res_sub(s4, s5, m), s6, m);

        o.v[0] = q0;
        o.v[1] = res_sub(a3, a6, m);
        o.v[2] = res_sub(a1, a4, m);
        o.v[3] = res_sub(a2, a5, m);
        o.v[4] = res_add(a2, a5, m);
        o.v[5] = res_add(a1, a4, m);
        o.v[6] = res_add(a3, a6, m);
        return o;
    endfunction

    function automatic word_t rand_word();
        return word_t'({$urandom, $urandom});
    endfunction

    // Residue mix: edges, unreduced values and values below the modulus.
    function automatic word_t pick_residue();
        case ($urandom_range(9))
            0: return '0;
            1: return cur_modulus - word_t'(1);
            2: return WORD_ONES;
            3: return cur_modulus;
            4, 5: return rand_word();
            default: return rand_word() % cur_modulus;
        endcase
    endfunction

    function automatic request_t make_xform();
        request_t r;
        r.op = OP_XFORM;
        r.idx = kidx_t'($urandom);
        r.cval = rand_word();
        for (int i = 0; i < NUM_RES; i++)
        begin
            r.x[i] = pick_residue();
        end
        return r;
    endfunction

    function automatic request_t make_load(kidx_t idx, word_t value);
        request_t r;
        r.op = OP_LOAD;
        r.idx = idx;
        r.cval = value;
        for (int i = 0; i < NUM_RES; i++)
        begin
            r.x[i] = rand_word();
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, word_t got, word_t want);
        mismatch_count++;
        $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    endtask

    // Offer one request, wait for acceptance, then update the prediction.
    task automatic send_request(request_t r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            req.valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        else
        begin
            @(negedge clk);
        end
        req.opcode = r.op;
        req.const_index = r.idx;
        req.const_value = r.cval;
        req.in_0 = r.x[0];
        req.in_1 = r.x[1];
        req.in_2 = r.x[2];
        req.in_3 = r.x[3];
        req.in_4 = r.x[4];
        req.in_5 = r.x[5];
        req.in_6 = r.x[6];
        req.valid = 1'b1;
        @(posedge clk);
        while (!req.ready)
        begin
            @(posedge clk);
        end
        if (r.op == OP_LOAD)
        begin
            const_table[r.idx] = r.cval;
            load_count++;
        end
        else
        begin
            pending_results.push_back(butterfly7(r));
            xform_count++;
        end
    endtask

    task automatic stop_sending();
        @(negedge clk);
        req.valid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Modulus write once the pipeline has gone quiet.
    task automatic set_modulus(word_t value);
        wait_drained();
        repeat (LATENCY + 8) @(posedge clk);
        @(negedge clk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        cur_modulus = (value < MIN_MODULUS) ? MIN_MODULUS : value;
        modulus_count++;
    endtask

    task automatic load_all_constants();
        for (int i = 0; i < NUM_K; i++)
        begin
            send_request(make_load(kidx_t'(i), pick_residue()));
        end
    endtask

    // Result checker: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        word_t got [NUM_RES];
        residues_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = '{res.out_0, res.out_1, res.out_2, res.out_3,
                    res.out_4, res.out_5, res.out_6};
            result_count++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result out_0", got[0], '0);
            end
            else
            begin
                want = pending_results.pop_front();
                for (int i = 0; i < NUM_RES; i++)
                begin
                    if (got[i] !== want.v[i])
                    begin
                        report_mismatch($sformatf("out_%0d", i), got[i], want.v[i]);
                    end
                end
            end
        end
    end

    // Result side readiness, with an optional long hold-off.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold_left > 0)
            begin
                res.ready = 1'b0;
                recv_hold_left--;
            end
            else
            begin
                res.ready = ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Extremes at the reset modulus and at the widest modulus, then moduli below three.
    task automatic test_directed();
        request_t r;
        send_request(make_load(kidx_t'(0), '0));
        send_request(make_load(kidx_t'(1), word_t'(1)));
        send_request(make_load(kidx_t'(2), word_t'(2)));
        send_request(make_load(kidx_t'(3), WORD_ONES));
        for (int i = 4; i < NUM_K; i++)
        begin
            send_request(make_load(kidx_t'(i), rand_word()));
        end
        r = make_xform();
        r.x = '{default: '0};
        send_request(r);
        r.x = '{default: WORD_ONES};
        send_request(r);
        r.x = '{default: word_t'(2)};
        send_request(r);
        set_modulus(WORD_ONES);
        for (int i = 0; i < NUM_RES; i++)
        begin
            r.x = '{default: '0};
            r.x[i] = WORD_ONES - word_t'(1);
            send_request(r);
        end
        send_request(make_load(kidx_t'(7), WORD_ONES));
        r.x = '{default: WORD_ONES - word_t'(1)};
        send_request(r);
        // A modulus below three is stored as three.
        set_modulus('0);
        send_request(make_xform());
        set_modulus(word_t'(2));
        send_request(make_xform());
    endtask

    task automatic test_random_traffic(int count, int s_pct, int r_pct, word_t modulus);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        set_modulus(modulus);
        load_all_constants();
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(99) < 15)
            begin
                send_request(make_load(kidx_t'($urandom), pick_residue()));
            end
            else
            begin
                send_request(make_xform());
            end
        end
    endtask

    // Long result stall while requests keep coming, then a full drain and further requests.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_modulus(word_t'(62'h3FFF_FFFF_FFFF_FFC5) | word_t'(1));
        @(negedge clk);
        recv_hold_left = 400;
        for (int n = 0; n < 150; n++)
        begin
            send_request(make_xform());
        end
        wait_drained();
        for (int n = 0; n < 20; n++)
        begin
            send_request(make_xform());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req.valid = 1'b0;
        req.opcode = OP_LOAD;
        req.const_index = '0;
        req.const_value = '0;
        req.in_0 = '0;
        req.in_1 = '0;
        req.in_2 = '0;
        req.in_3 = '0;
        req.in_4 = '0;
        req.in_5 = '0;
        req.in_6 = '0;
        cur_modulus = MIN_MODULUS;
        const_table = '{default: '0};
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_left = 0;
        mismatch_count = 0;
        xform_count = 0;
        load_count = 0;
        result_count = 0;
        modulus_count = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random_traffic(220, 31, 82, word_t'(62'h1FFF_FFFF_FFFF_FFFF));
        test_random_traffic(220, 82, 31, rand_word() | word_t'(1));
        test_random_traffic(50, 0, 0, word_t'(7));
        test_random_traffic(50, 0, 0, rand_word() & ~word_t'(1));
        test_random_traffic(130, 0, 0, WORD_ONES);
        test_backpressure();

        wait_drained();
        repeat (LATENCY + 20) @(posedge clk);
        $display("Run covered %0d transforms, %0d constant loads, %0d modulus settings.",
                 xform_count, load_count, modulus_count);
        $display("Checked %0d results, %0d field mismatches.", result_count, mismatch_count);
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ ntt_radix7_butterfly_unit.f @@
rtl/ntt7_pkg.sv
rtl/ntt7_if.sv
rtl/ntt7_reduce.sv
rtl/ntt7_mul.sv
rtl/ntt7_presum.sv
rtl/ntt7_combine.sv
rtl/ntt_radix7_butterfly_unit.sv
tb/sv/tb_ntt_radix7_butterfly_unit.sv
